/* rtl/tsc_pkg.sv */
package tsc_pkg;

  localparam int FreqW   = 16;
  localparam int EnergyW = 24;
  localparam int SumW    = EnergyW + 1;
  localparam int ProdW   = FreqW + EnergyW;
  localparam int NumW    = ProdW + 1;
  localparam int RatioW  = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;
  localparam int InDataW  = 160;
  localparam int OutDataW = 112;
  localparam int QDepth   = 2;

  localparam logic [SumW-1:0] BradyLow2  = 25'd128;
  localparam logic [SumW-1:0] BradyHigh2 = 25'd8192;
  localparam logic [SumW-1:0] DyskLow2   = 25'd131072;

  localparam logic [FreqW-1:0] Hz2p5 = 16'd640;
  localparam logic [FreqW-1:0] Hz3   = 16'd768;
  localparam logic [FreqW-1:0] Hz4   = 16'd1024;
  localparam logic [FreqW-1:0] Hz5   = 16'd1280;
  localparam logic [FreqW-1:0] Hz7   = 16'd1792;
  localparam logic [FreqW-1:0] Hz1p5 = 16'd384;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BAND_LOW = 3'd0, REG_BAND_HIGH = 3'd1, REG_DOM_MIN = 3'd2,
    REG_PEAK_MATCH = 3'd3, REG_RATIO_MIN = 3'd4, REG_RATIO_STRICT = 3'd5,
    REG_COH_MAX = 3'd6, REG_TEN_MIN = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0, KIND_TREMOR = 2'd1, KIND_DYSK = 2'd2, KIND_BRADY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0, ST_DIV = 2'd1, ST_CLASS = 2'd2, ST_DONE = 2'd3
  } back_state_t;

  typedef struct packed {
    logic [NumW-1:0]    t_num;
    logic [SumW-1:0]    t_sum;
    logic [NumW-1:0]    w_num;
    logic [SumW-1:0]    w_sum;
    logic [FreqW-1:0]   spread;
  } job_t;

  typedef struct packed {
    logic [FreqW-1:0] band_low;
    logic [FreqW-1:0] band_high;
    logic [FreqW-1:0] dom_min;
    logic [FreqW-1:0] peak_match;
    logic [RatioW-1:0] ratio_min;
    logic [RatioW-1:0] ratio_strict;
    logic [FreqW-1:0] coh_max;
    logic [EnergyW-1:0] ten_min;
  } cfg_t;

endpackage

/* rtl/tsc_front.sv */
module tsc_front
  import tsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [InDataW-1:0] in_tdata,
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job
);

  // stage 1: register products; stage 2: sums
  logic              s1_v_r, s1_v_nxt;
  logic [ProdW-1:0]  p_tm_r, p_tz_r, p_wm_r, p_wz_r;
  logic [EnergyW-1:0] tem_r, tez_r, wem_r, wez_r;
  logic [FreqW-1:0]  tpm_r, tpz_r;
  logic              s2_v_r, s2_v_nxt;
  job_t              job_r;
  logic              adv2, adv1;

  assign adv2 = !s2_v_r || job_ready;
  assign adv1 = !s1_v_r || adv2;
  assign in_tready = adv1;
  assign s1_v_nxt = adv1 ? in_tvalid : s1_v_r;
  assign s2_v_nxt = adv2 ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_tvalid) begin
      p_wm_r <= in_tdata[15:0] * in_tdata[55:32];
      p_wz_r <= in_tdata[31:16] * in_tdata[79:56];
      p_tm_r <= in_tdata[95:80] * in_tdata[135:112];
      p_tz_r <= in_tdata[111:96] * in_tdata[159:136];
      wem_r <= in_tdata[55:32];
      wez_r <= in_tdata[79:56];
      tem_r <= in_tdata[135:112];
      tez_r <= in_tdata[159:136];
      tpm_r <= in_tdata[95:80];
      tpz_r <= in_tdata[111:96];
    end
    if (adv2 && s1_v_r) begin
      job_r.t_num <= {1'b0, p_tm_r} + {1'b0, p_tz_r};
      job_r.w_num <= {1'b0, p_wm_r} + {1'b0, p_wz_r};
      job_r.t_sum <= {1'b0, tem_r} + {1'b0, tez_r};
      job_r.w_sum <= {1'b0, wem_r} + {1'b0, wez_r};
      job_r.spread <= (tpm_r >= tpz_r) ? tpm_r - tpz_r : tpz_r - tpm_r;
    end
  end

  assign job_valid = s2_v_r;
  assign job = job_r;

endmodule

/* rtl/tsc_queue.sv */
module tsc_queue
  import tsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  localparam int PtrW = $clog2(QDepth);
  job_t            mem_r [QDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  logic            push, pop;

  assign wr_ready = cnt_r != QDepth[PtrW:0];
  assign rd_valid = cnt_r != '0;
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QDepth[PtrW:0]) else $error("queue count overflow");
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 1'b1) else $error("pop count");
  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("push count");
`endif

endmodule

/* rtl/tsc_back.sv */
module tsc_back
  import tsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                job_valid,
  output logic                job_ready,
  input  job_t                job,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata
);

  // Three restoring dividers run in parallel, one quotient bit per cycle.
  localparam int DivSteps = NumW;
  localparam int CntW = $clog2(DivSteps + 1);

  back_state_t st_r, st_nxt;
  logic [CntW-1:0] cnt_r;
  job_t            j_r;
  logic [NumW-1:0] qt_r, qw_r, qr_r;
  logic [SumW:0]   rt_r, rw_r, rr_r;
  logic [NumW-1:0] nr_r;

  logic [FreqW-1:0] t_hz, w_hz, gap, spread;
  logic [RatioW-1:0] ratio;
  logic [SumW-1:0]  tsum, wsum, tmin2;
  logic [SumW:0]    rt_s, rw_s, rr_s;
  logic in_band, agree, present, brady, dh, dw, di, reg_t;
  kind_t kind;

  logic             ov_r;
  logic [OutDataW-1:0] od_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (job_valid) st_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == CntW'(DivSteps - 1)) st_nxt = ST_CLASS;
      ST_CLASS: st_nxt = ST_DONE;
      ST_DONE:  if (!ov_r || out_tready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready = 1'b0;
    case (st_r)
      ST_IDLE: job_ready = 1'b1;
      default: job_ready = 1'b0;
    endcase
  end

  assign rt_s = {rt_r[SumW-1:0], qt_r[NumW-1]};
  assign rw_s = {rw_r[SumW-1:0], qw_r[NumW-1]};
  assign rr_s = {rr_r[SumW-1:0], nr_r[NumW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE && (!ov_r || out_tready)) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        j_r <= job;
        cnt_r <= '0;
        qt_r <= job.t_num;
        qw_r <= job.w_num;
        nr_r <= {job.t_sum, 14'd0, 2'd0} >> 2;
        qr_r <= '0;
        rt_r <= '0;
        rw_r <= '0;
        rr_r <= '0;
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (rt_s >= {1'b0, j_r.t_sum}) begin
          rt_r <= rt_s - {1'b0, j_r.t_sum};
          qt_r <= {qt_r[NumW-2:0], 1'b1};
        end else begin
          rt_r <= rt_s;
          qt_r <= {qt_r[NumW-2:0], 1'b0};
        end
        if (rw_s >= {1'b0, j_r.w_sum}) begin
          rw_r <= rw_s - {1'b0, j_r.w_sum};
          qw_r <= {qw_r[NumW-2:0], 1'b1};
        end else begin
          rw_r <= rw_s;
          qw_r <= {qw_r[NumW-2:0], 1'b0};
        end
        nr_r <= {nr_r[NumW-2:0], 1'b0};
        if (rr_s >= {1'b0, j_r.w_sum}) begin
          rr_r <= rr_s - {1'b0, j_r.w_sum};
          qr_r <= {qr_r[NumW-2:0], 1'b1};
        end else begin
          rr_r <= rr_s;
          qr_r <= {qr_r[NumW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // classification from the finished quotients
  always_comb begin
    tsum = j_r.t_sum;
    wsum = j_r.w_sum;
    spread = j_r.spread;
    tmin2 = {cfg.ten_min, 1'b0};
    t_hz = (tsum == '0) ? '0 : qt_r[FreqW-1:0];
    w_hz = (wsum == '0) ? '0 : qw_r[FreqW-1:0];
    gap = (w_hz >= t_hz) ? w_hz - t_hz : t_hz - w_hz;
    if (wsum == '0) ratio = '0;
    else if (qr_r[NumW-1:RatioW] != '0) ratio = '1;
    else ratio = qr_r[RatioW-1:0];
    brady = wsum >= BradyLow2 && wsum < BradyHigh2 && w_hz != '0 && w_hz < Hz2p5;
    in_band = t_hz >= cfg.band_low && t_hz <= cfg.band_high;
    agree = (w_hz >= cfg.dom_min) ||
            (gap <= cfg.peak_match && ratio >= cfg.ratio_strict && in_band);
    present = ratio >= cfg.ratio_min && in_band && agree;
    dh = tsum >= DyskLow2 && t_hz >= Hz4 && t_hz <= cfg.band_high;
    dw = tsum >= tmin2 && t_hz >= Hz4 && t_hz <= cfg.band_high && spread > Hz1p5;
    di = tsum >= tmin2 && t_hz >= Hz5 && gap > cfg.coh_max;
    reg_t = tsum >= tmin2 && t_hz >= Hz3 && t_hz <= Hz7 &&
            spread <= Hz1p5 && gap <= cfg.coh_max;
    if (brady) kind = KIND_BRADY;
    else if (present && (dh || dw || di)) kind = KIND_DYSK;
    else if (present && reg_t) kind = KIND_TREMOR;
    else kind = KIND_NONE;
  end

  // load the output register only once the previous transfer has left it
  always_ff @(posedge clk) begin
    if (st_r == ST_DONE && (!ov_r || out_tready)) begin
      od_r <= {6'd0, gap, tsum[SumW-1:1], ratio, spread, w_hz, t_hz, kind};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !job_ready) else $error("took job while busy");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLASS |-> $past(st_r) == ST_DIV) else $error("class w/o divide");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
`endif

endmodule

/* rtl/tremor_spectrum_classifier.sv */
// Tremor spectrum classifier. Takes one spectral summary per transfer and
// returns one classification per transfer. The front end registers the four
// frequency-energy products, then the band sums (one item per cycle unless
// the queue stalls it); a two-entry queue feeds the back end, whose three
// bit-serial dividers work on one item at a time: the back end takes the
// job, divides, classifies and loads the output register before it takes
// the next job. A stalled result waits in the output register while
// the next item divides.
// Configuration registers must be written while the block is idle.
module tremor_spectrum_classifier
  import tsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // wide_peak_mag_hz, wide_peak_z_hz, wide_energy_mag, wide_energy_z,
  // tremor_peak_mag_hz, tremor_peak_z_hz, tremor_energy_mag, tremor_energy_z
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // kind, tremor_freq_hz, wide_freq_hz, axis_spread_hz, energy_ratio,
  // mean_tremor_energy, peak_gap_hz, zero fill
  output logic [OutDataW-1:0] out_tdata
);

  cfg_t cfg_r;
  logic f_v, f_r, q_v, q_r;
  job_t f_j, q_j;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_low <= 16'd768;
      cfg_r.band_high <= 16'd3072;
      cfg_r.dom_min <= 16'd768;
      cfg_r.peak_match <= 16'd256;
      cfg_r.ratio_min <= 16'd4915;
      cfg_r.ratio_strict <= 16'd8192;
      cfg_r.coh_max <= 16'd384;
      cfg_r.ten_min <= 24'd256;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BAND_LOW:     cfg_r.band_low <= cfg_wdata[15:0];
        REG_BAND_HIGH:    cfg_r.band_high <= cfg_wdata[15:0];
        REG_DOM_MIN:      cfg_r.dom_min <= cfg_wdata[15:0];
        REG_PEAK_MATCH:   cfg_r.peak_match <= cfg_wdata[15:0];
        REG_RATIO_MIN:    cfg_r.ratio_min <= cfg_wdata[15:0];
        REG_RATIO_STRICT: cfg_r.ratio_strict <= cfg_wdata[15:0];
        REG_COH_MAX:      cfg_r.coh_max <= cfg_wdata[15:0];
        REG_TEN_MIN:      cfg_r.ten_min <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tsc_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .job_valid(f_v), .job_ready(f_r), .job(f_j));

  tsc_queue u_queue (.clk, .rst_n, .wr_valid(f_v), .wr_ready(f_r), .wr_data(f_j),
    .rd_valid(q_v), .rd_ready(q_r), .rd_data(q_j));

  tsc_back u_back (.clk, .rst_n, .cfg(cfg_r), .job_valid(q_v), .job_ready(q_r),
    .job(q_j), .out_tvalid, .out_tready, .out_tdata);

endmodule

/* verif/tremor_spectrum_classifier_tb.sv */
module tremor_spectrum_classifier_tb;
  import tsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] wpm, wpz;
    logic [23:0] wem, wez;
    logic [15:0] tpm, tpz;
    logic [23:0] tem, tez;
  } spectrum_t;

  typedef struct packed {
    logic [15:0] gap;
    logic [23:0] mean_t;
    logic [15:0] ratio;
    logic [15:0] spread;
    logic [15:0] w_hz;
    logic [15:0] t_hz;
    kind_t       kind;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  cfg_t     thr;
  verdict_t verdict_q[$];
  int       n_errors = 0;
  bit       no_idle = 1'b0;
  int       stall_left = 0;

  tremor_spectrum_classifier i_dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] weigh(logic [63:0] pm, logic [63:0] pz,
                                        logic [63:0] em, logic [63:0] ez);
    if (em + ez == 0) return 0;
    return (pm * em + pz * ez) / (em + ez);
  endfunction

  function automatic verdict_t classify(spectrum_t s);
    verdict_t    v;
    logic [63:0] tsum, wsum, t_hz, w_hz, spread, gap, ratio, t_min2;
    bit          in_band, agree, present, dysk;
    tsum   = 64'(s.tem) + 64'(s.tez);
    wsum   = 64'(s.wem) + 64'(s.wez);
    t_hz   = weigh(64'(s.tpm), 64'(s.tpz), 64'(s.tem), 64'(s.tez));
    w_hz   = weigh(64'(s.wpm), 64'(s.wpz), 64'(s.wem), 64'(s.wez));
    spread = (s.tpm >= s.tpz) ? 64'(s.tpm - s.tpz) : 64'(s.tpz - s.tpm);
    gap    = (w_hz >= t_hz) ? w_hz - t_hz : t_hz - w_hz;
    t_min2 = 2 * 64'(thr.ten_min);
    ratio  = 0;
    if (wsum != 0) begin
      ratio = (tsum << 14) / wsum;
      if (ratio > 64'hFFFF) ratio = 64'hFFFF;
    end
    v.kind = KIND_NONE;
    if (wsum >= 128 && wsum < 8192 && w_hz > 0 && w_hz < 640) begin
      v.kind = KIND_BRADY;
    end else begin
      in_band = t_hz >= thr.band_low && t_hz <= thr.band_high;
      agree   = w_hz >= thr.dom_min ||
                (gap <= thr.peak_match && ratio >= thr.ratio_strict && in_band);
      present = ratio >= thr.ratio_min && in_band && agree;
      if (present) begin
        dysk = (tsum >= 131072 && t_hz >= 1024 && t_hz <= thr.band_high) ||
               (tsum >= t_min2 && t_hz >= 1024 && t_hz <= thr.band_high &&
                spread > 384) ||
               (tsum >= t_min2 && t_hz >= 1280 && gap > thr.coh_max);
        if (dysk)
          v.kind = KIND_DYSK;
        else if (tsum >= t_min2 && t_hz >= 768 && t_hz <= 1792 &&
                 spread <= 384 && gap <= thr.coh_max)
          v.kind = KIND_TREMOR;
      end
    end
    v.t_hz   = t_hz[15:0];
    v.w_hz   = w_hz[15:0];
    v.spread = spread[15:0];
    v.ratio  = ratio[15:0];
    v.mean_t = tsum[24:1];
    v.gap    = gap[15:0];
    return v;
  endfunction

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return;
    in_tvalid <= 1'b0;
    if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(20, 80)) @(posedge clk);
  endtask

  task automatic send_spectrum(spectrum_t s);
    verdict_q.push_back(classify(s));
    in_tdata  <= {s.tez, s.tem, s.tpz, s.tpm, s.wez, s.wem, s.wpz, s.wpm};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    idle_gap();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // close each write with an idle cycle so back-to-back writes never
  // drive the enable twice in one time step
  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BAND_LOW:     thr.band_low     = val[15:0];
      REG_BAND_HIGH:    thr.band_high    = val[15:0];
      REG_DOM_MIN:      thr.dom_min      = val[15:0];
      REG_PEAK_MATCH:   thr.peak_match   = val[15:0];
      REG_RATIO_MIN:    thr.ratio_min    = val[15:0];
      REG_RATIO_STRICT: thr.ratio_strict = val[15:0];
      REG_COH_MAX:      thr.coh_max      = val[15:0];
      default:          thr.ten_min      = val;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] near(int unsigned base);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(base / 2, base * 2));
  endfunction

  function automatic spectrum_t make_spectrum();
    spectrum_t s;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    s.wpm = 16'($urandom); s.wpz = 16'($urandom);
    s.tpm = 16'($urandom); s.tpz = 16'($urandom);
    s.wem = 24'($urandom); s.wez = 24'($urandom);
    s.tem = 24'($urandom); s.tez = 24'($urandom);
    case (mode)
      0, 1: ;  // raw noise over the full field ranges
      2: begin  // slow, weak wide band
        s.wpm = 16'($urandom_range(0, 700)); s.wpz = 16'($urandom_range(0, 700));
        s.wem = 24'($urandom_range(0, 4200)); s.wez = 24'($urandom_range(0, 4200));
        s.tem = 24'($urandom_range(0, 5000)); s.tez = 24'($urandom_range(0, 5000));
      end
      default: begin  // tremor-shaped spectrum, peaks close together
        s.tpm = 16'($urandom_range(500, 3300));
        s.tpz = 16'(int'(s.tpm) + $urandom_range(0, 900) - 450);
        s.wpm = 16'(int'(s.tpm) + $urandom_range(0, 1000) - 500);
        s.wpz = 16'(int'(s.tpz) + $urandom_range(0, 1000) - 500);
        s.tem = 24'((mode > 6) ? $urandom_range(0, 300000) : $urandom_range(0, 2000));
        s.tez = 24'((mode > 6) ? $urandom_range(0, 300000) : $urandom_range(0, 2000));
        s.wem = 24'(s.tem + $urandom_range(0, 2 * s.tem + 10));
        s.wez = 24'(s.tez + $urandom_range(0, 2 * s.tez + 10));
        if (mode == 9) begin s.wem = '0; s.wez = '0; end
      end
    endcase
    return s;
  endfunction

  task automatic test_directed();
    spectrum_t s;
    s = '{default: '0};
    send_spectrum(s);                                  // all zero
    s = '{16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
          16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF};
    send_spectrum(s);                                  // all max
    s = '{16'd0, 16'hFFFF, 24'd0, 24'hFFFFFF, 16'hFFFF, 16'd0, 24'hFFFFFF, 24'd0};
    send_spectrum(s);                                  // one axis zero weight
    s = '{16'd400, 16'd500, 24'd100, 24'd100, 16'd1200, 16'd1200, 24'd10, 24'd10};
    send_spectrum(s);                                  // bradykinesia
    s = '{16'd400, 16'd500, 24'd64, 24'd63, 16'd1200, 16'd1200, 24'd10, 24'd10};
    send_spectrum(s);                                  // just below brady floor
    s = '{16'd400, 16'd500, 24'd4096, 24'd4095, 16'd1200, 16'd1200, 24'd10, 24'd10};
    send_spectrum(s);                                  // just below brady ceiling
    s = '{16'd1280, 16'd1300, 24'd2000, 24'd2000, 16'd1280, 16'd1300,
          24'd1500, 24'd1500};
    send_spectrum(s);                                  // regular tremor
    s = '{16'd1280, 16'd1300, 24'd200000, 24'd200000, 16'd1280, 16'd1300,
          24'd65536, 24'd65536};
    send_spectrum(s);                                  // dyskinesia, high energy
    s = '{16'd1280, 16'd1300, 24'd2000, 24'd2000, 16'd1000, 16'd1800,
          24'd1500, 24'd1500};
    send_spectrum(s);                                  // dyskinesia, wide spread
    s = '{16'd2500, 16'd2500, 24'd2000, 24'd2000, 16'd1400, 16'd1400,
          24'd1500, 24'd1500};
    send_spectrum(s);                                  // dyskinesia, incoherent
    s = '{16'd700, 16'd700, 24'd2000, 24'd2000, 16'd900, 16'd900,
          24'd1500, 24'd1500};
    send_spectrum(s);                                  // slow wide peak, agreement
    s = '{16'd1280, 16'd1300, 24'd0, 24'd0, 16'd1280, 16'd1300, 24'd500, 24'd500};
    send_spectrum(s);                                  // zero wide energy
    s = '{16'd1280, 16'd1300, 24'd1, 24'd0, 16'd1280, 16'd1300,
          24'hFFFFFF, 24'hFFFFFF};
    send_spectrum(s);                                  // saturated ratio
    s = '{16'd1280, 16'd1300, 24'd2000, 24'd2000, 16'd1280, 16'd1300,
          24'd256, 24'd255};
    send_spectrum(s);                                  // energy one below minimum
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) == 0) no_idle = ~no_idle;
      send_spectrum(make_spectrum());
    end
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_config_sweep();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0 || phase == 1) begin
        for (int r = 0; r < 8; r++)
          write_reg(cfg_reg_t'(r), (phase == 0) ? 24'h0 :
                    (r == REG_TEN_MIN) ? 24'hFFFFFF : 24'hFFFF);
      end else begin
        write_reg(REG_BAND_LOW, 24'(near(768)));
        write_reg(REG_BAND_HIGH, 24'(near(3072)));
        write_reg(REG_DOM_MIN, 24'(near(768)));
        write_reg(REG_PEAK_MATCH, 24'(near(256)));
        write_reg(REG_RATIO_MIN, 24'(near(4915)));
        write_reg(REG_RATIO_STRICT, 24'(near(8192)));
        write_reg(REG_COH_MAX, 24'(near(384)));
        write_reg(REG_TEN_MIN, ($urandom_range(0, 7) == 0) ? 24'($urandom) :
                  24'($urandom_range(0, 4000)));
      end
      test_random(150);
    end
  endtask

  task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (no_idle || $urandom_range(0, 99) < 75) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(20, 80);
    end
  end

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[105:0];
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual %h", $time, got);
        n_errors++;
      end else begin
        want = verdict_q.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("tremor_freq_hz", want.t_hz, got.t_hz);
        check_field("wide_freq_hz", want.w_hz, got.w_hz);
        check_field("axis_spread_hz", want.spread, got.spread);
        check_field("energy_ratio", want.ratio, got.ratio);
        check_field("mean_tremor_energy", want.mean_t, got.mean_t);
        check_field("peak_gap_hz", want.gap, got.gap);
      end
    end
  end

  initial begin
    thr = '{band_low: 768, band_high: 3072, dom_min: 768, peak_match: 256,
            ratio_min: 4915, ratio_strict: 8192, coh_max: 384, ten_min: 256};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(450);
    test_config_sweep();
    if (n_errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
